@@ design/nsfe_pkg.sv @@
// Package: shared types and constants for the NMEA sentence field extractor.
`timescale 1ns / 1ps

package nsfe_pkg;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_RMC  = 3'd1,
		KIND_GSA  = 3'd2,
		KIND_GGA  = 3'd3,
		KIND_VTG  = 3'd4
	} kind_t;

	localparam logic [3:0] FLD_TIME   = 4'd0;
	localparam logic [3:0] FLD_LAT    = 4'd1;
	localparam logic [3:0] FLD_NS     = 4'd2;
	localparam logic [3:0] FLD_LON    = 4'd3;
	localparam logic [3:0] FLD_EW     = 4'd4;
	localparam logic [3:0] FLD_SATS   = 4'd5;
	localparam logic [3:0] FLD_HDOP   = 4'd6;
	localparam logic [3:0] FLD_ALT    = 4'd7;
	localparam logic [3:0] FLD_SPEED  = 4'd8;
	localparam logic [3:0] FLD_COURSE = 4'd9;
	localparam logic [3:0] FLD_DATE   = 4'd10;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_V       = 8'h56;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_TWO     = 8'h32;

	// comma count forced by a NUL byte so that no field matches until '$'
	localparam logic [7:0] COMMA_PARK = 8'd25;
	localparam logic [7:0] COMMA_MAX  = 8'd255;

	typedef struct packed {
		logic [7:0] byte_in;
	} in_item_t;

	typedef struct packed {
		logic       store_en;
		logic [3:0] field_id;
		logic [3:0] char_pos;
		logic [7:0] char_out;
		logic       field_overflow;
		logic       fix_valid;
		logic       sentence_done;
	} out_item_t;

	typedef logic [0:0] cfg_item_t;

endpackage

@@ design/nsfe_chan_if.sv @@
// Interface: valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface nsfe_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/nmea_sentence_field_extractor_unit.sv @@
// Top level: NMEA 0183 sentence field extractor with a registered result.
`timescale 1ns / 1ps

// Usage:
// rx carries one received ASCII byte per transaction; res returns exactly one
// result per byte: a captured field character with its field number and
// position, an overflow mark when the field is full, the current fix-valid
// flag, and a completion mark on the newline that ends an RMC or GGA sentence.
// cfg writes the aprs_mode bit (reduced field map); it is always ready. The user
// must write it only while no byte is in flight; the block itself does not enforce this.
// The result of a byte appears on res in the cycle after the byte is
// accepted. Throughput: one byte per cycle unless res stalls; the parser state
// (comma count, field position, sentence kind, fix flag) updates in the cycle
// of acceptance. The single result register sets the figure: rx is ready
// whenever that register is empty or is being drained in the same cycle.
// When res stalls, the pending result holds and rx accepts nothing further.
// Reset (arst_n low) clears the parser state, aprs_mode and the result valid.
// FIELD_LEN sets how many characters of one field are captured before the
// rest are dropped and flagged.

module nmea_sentence_field_extractor_unit #(
	parameter int FIELD_LEN = 16
) (
	input  logic clk,
	input  logic arst_n,
	nsfe_chan_if.sink   cfg,
	nsfe_chan_if.sink   rx,
	nsfe_chan_if.source res
);

	localparam int POS_W = $clog2(FIELD_LEN + 1);

	logic                   aprs_q;
	logic [7:0]             comma_q;
	logic [POS_W-1:0]       pos_q;
	nsfe_pkg::kind_t        kind_q;
	logic                   valid_flag_q;

	nsfe_pkg::out_item_t    res_q;
	logic                   res_valid_q;

	logic                   accept;
	logic [7:0]             b;

	logic [7:0]             comma_d;
	logic [POS_W-1:0]       pos_d;
	nsfe_pkg::kind_t        kind_d;
	logic                   valid_flag_d;
	nsfe_pkg::out_item_t    res_d;

	logic                   hit;
	logic [3:0]             fld;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !res_valid_q || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign b         = rx.data.byte_in;

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Field map lookup; also updates the fix flag on the indicator fields.
	always_comb begin
		hit          = 1'b0;
		fld          = nsfe_pkg::FLD_TIME;
		valid_flag_d = valid_flag_q;
		case (kind_q)
			nsfe_pkg::KIND_GGA: begin
				case (comma_q)
					8'd1: begin hit = 1'b1; fld = nsfe_pkg::FLD_TIME; end
					8'd2: begin hit = 1'b1; fld = nsfe_pkg::FLD_LAT; end
					8'd3: begin hit = 1'b1; fld = nsfe_pkg::FLD_NS; end
					8'd4: begin hit = 1'b1; fld = nsfe_pkg::FLD_LON; end
					8'd5: begin hit = 1'b1; fld = nsfe_pkg::FLD_EW; end
					8'd6: valid_flag_d = (b == nsfe_pkg::CH_ONE) || (b == nsfe_pkg::CH_TWO);
					8'd7: begin hit = 1'b1; fld = nsfe_pkg::FLD_SATS; end
					8'd8: begin hit = !aprs_q; fld = nsfe_pkg::FLD_HDOP; end
					8'd9: begin hit = 1'b1; fld = nsfe_pkg::FLD_ALT; end
					default: ;
				endcase
			end
			nsfe_pkg::KIND_RMC: begin
				case (comma_q)
					8'd2: valid_flag_d = (b == nsfe_pkg::CH_A);
					8'd7: begin hit = aprs_q; fld = nsfe_pkg::FLD_SPEED; end
					8'd8: begin hit = aprs_q; fld = nsfe_pkg::FLD_COURSE; end
					8'd9: begin hit = !aprs_q; fld = nsfe_pkg::FLD_DATE; end
					default: ;
				endcase
			end
			nsfe_pkg::KIND_VTG: begin
				case (comma_q)
					8'd1: begin hit = 1'b1; fld = nsfe_pkg::FLD_COURSE; end
					8'd7: begin hit = 1'b1; fld = nsfe_pkg::FLD_SPEED; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Next parser state and result for the byte on rx.
	always_comb begin
		comma_d                = comma_q;
		pos_d                  = pos_q;
		kind_d                 = kind_q;
		res_d                  = '0;
		res_d.fix_valid        = valid_flag_q;
		if (b == nsfe_pkg::CH_NUL) begin
			comma_d         = nsfe_pkg::COMMA_PARK;
			kind_d          = nsfe_pkg::KIND_NONE;
			res_d.fix_valid = 1'b0;
		end else if (b == nsfe_pkg::CH_DOLLAR) begin
			comma_d = '0;
			kind_d  = nsfe_pkg::KIND_NONE;
		end else if (b == nsfe_pkg::CH_COMMA) begin
			if (comma_q != nsfe_pkg::COMMA_MAX) begin
				comma_d = comma_q + 8'd1;
			end
			pos_d = '0;
		end else if (b == nsfe_pkg::CH_NEWLINE &&
				(kind_q == nsfe_pkg::KIND_RMC || kind_q == nsfe_pkg::KIND_GGA)) begin
			res_d.sentence_done = 1'b1;
		end else if (comma_q == '0) begin
			// sentence name letters select the kind; GSV falls through to VTG unless aprs_mode is set
			if (b == nsfe_pkg::CH_C) begin
				kind_d = nsfe_pkg::KIND_RMC;
			end else if (b == nsfe_pkg::CH_S) begin
				kind_d = nsfe_pkg::KIND_GSA;
			end else if (b == nsfe_pkg::CH_A) begin
				if (kind_q != nsfe_pkg::KIND_GSA) begin
					kind_d = nsfe_pkg::KIND_GGA;
				end
			end else if (b == nsfe_pkg::CH_V && !aprs_q) begin
				kind_d = nsfe_pkg::KIND_VTG;
			end
		end else begin
			res_d.fix_valid = valid_flag_d;
			if (hit) begin
				res_d.field_id = fld;
				res_d.char_out = b;
				if (pos_q >= POS_W'(FIELD_LEN)) begin
					res_d.field_overflow = 1'b1;
				end else begin
					res_d.store_en = 1'b1;
					res_d.char_pos = 4'(pos_q);
					pos_d          = pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aprs_q       <= 1'b0;
			comma_q      <= '0;
			pos_q        <= '0;
			kind_q       <= nsfe_pkg::KIND_NONE;
			valid_flag_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				aprs_q <= cfg.data[0];
			end
			if (accept) begin
				comma_q      <= comma_d;
				pos_q        <= pos_d;
				kind_q       <= kind_d;
				valid_flag_q <= res_d.fix_valid;
				res_valid_q  <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

endmodule

@@ dv/testbench.sv @@
// Testbench for the NMEA sentence field extractor: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module testbench;

	localparam int FIELD_LEN   = 16;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_LIMIT  = 4000;

	logic clk;
	logic arst_n;

	nsfe_chan_if #(.T(nsfe_pkg::cfg_item_t)) cfg_ch ();
	nsfe_chan_if #(.T(nsfe_pkg::in_item_t))  rx_ch ();
	nsfe_chan_if #(.T(nsfe_pkg::out_item_t)) res_ch ();

	nmea_sentence_field_extractor_unit #(
		.FIELD_LEN(FIELD_LEN)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	// parser state as the block should hold it
	logic [7:0]      commas    = '0;
	logic [4:0]      fpos      = '0;
	nsfe_pkg::kind_t kind_now  = nsfe_pkg::KIND_NONE;
	logic            fix_flag  = 1'b0;
	logic            aprs_on   = 1'b0;

	nsfe_pkg::out_item_t expected_captures [$];
	int         fail_count = 0;
	int         bytes_sent = 0;
	int         burst_left = 0;
	int         hold_seq   = 0;
	int         idle_cycles = 0;

	// receiver pattern state
	int         hold_seen = 0;
	int         hold_left = 0;
	int         stall_mode = 0;
	int         stall_span = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic nsfe_pkg::out_item_t parse_byte(input logic [7:0] b);
		nsfe_pkg::out_item_t r;
		logic       hit;
		logic [3:0] fld;
		r   = '0;
		hit = 1'b0;
		fld = '0;
		if (b == nsfe_pkg::CH_NUL) begin
			commas   = nsfe_pkg::COMMA_PARK;
			kind_now = nsfe_pkg::KIND_NONE;
			fix_flag = 1'b0;
		end else if (b == nsfe_pkg::CH_DOLLAR) begin
			commas   = '0;
			kind_now = nsfe_pkg::KIND_NONE;
		end else if (b == nsfe_pkg::CH_COMMA) begin
			if (commas != nsfe_pkg::COMMA_MAX)
				commas = commas + 8'd1;
			fpos = '0;
		end else if (b == nsfe_pkg::CH_NEWLINE &&
				(kind_now == nsfe_pkg::KIND_RMC || kind_now == nsfe_pkg::KIND_GGA)) begin
			r.sentence_done = 1'b1;
		end else if (commas == 8'd0) begin
			if (b == nsfe_pkg::CH_C)
				kind_now = nsfe_pkg::KIND_RMC;
			else if (b == nsfe_pkg::CH_S)
				kind_now = nsfe_pkg::KIND_GSA;
			else if (b == nsfe_pkg::CH_A) begin
				if (kind_now != nsfe_pkg::KIND_GSA)
					kind_now = nsfe_pkg::KIND_GGA;
			end else if (b == nsfe_pkg::CH_V && !aprs_on)
				kind_now = nsfe_pkg::KIND_VTG;
		end else begin
			case (kind_now)
				nsfe_pkg::KIND_GGA: begin
					case (commas)
						8'd1: begin hit = 1'b1; fld = nsfe_pkg::FLD_TIME; end
						8'd2: begin hit = 1'b1; fld = nsfe_pkg::FLD_LAT; end
						8'd3: begin hit = 1'b1; fld = nsfe_pkg::FLD_NS; end
						8'd4: begin hit = 1'b1; fld = nsfe_pkg::FLD_LON; end
						8'd5: begin hit = 1'b1; fld = nsfe_pkg::FLD_EW; end
						8'd6: fix_flag = (b == nsfe_pkg::CH_ONE || b == nsfe_pkg::CH_TWO);
						8'd7: begin hit = 1'b1; fld = nsfe_pkg::FLD_SATS; end
						8'd8: begin hit = !aprs_on; fld = nsfe_pkg::FLD_HDOP; end
						8'd9: begin hit = 1'b1; fld = nsfe_pkg::FLD_ALT; end
						default: ;
					endcase
				end
				nsfe_pkg::KIND_RMC: begin
					case (commas)
						8'd2: fix_flag = (b == nsfe_pkg::CH_A);
						8'd7: begin hit = aprs_on; fld = nsfe_pkg::FLD_SPEED; end
						8'd8: begin hit = aprs_on; fld = nsfe_pkg::FLD_COURSE; end
						8'd9: begin hit = !aprs_on; fld = nsfe_pkg::FLD_DATE; end
						default: ;
					endcase
				end
				nsfe_pkg::KIND_VTG: begin
					if (commas == 8'd1) begin
						hit = 1'b1;
						fld = nsfe_pkg::FLD_COURSE;
					end else if (commas == 8'd7) begin
						hit = 1'b1;
						fld = nsfe_pkg::FLD_SPEED;
					end
				end
				default: ;
			endcase
			if (hit) begin
				r.field_id = fld;
				r.char_out = b;
				if (fpos >= FIELD_LEN) begin
					r.field_overflow = 1'b1;
				end else begin
					r.store_en = 1'b1;
					r.char_pos = fpos[3:0];
					fpos       = fpos + 5'd1;
				end
			end
		end
		r.fix_valid = fix_flag;
		return r;
	endfunction

	function automatic string show(input nsfe_pkg::out_item_t r);
		return $sformatf("store=%0b field=%0d pos=%0d char=%02h ovf=%0b fix=%0b done=%0b",
			r.store_en, r.field_id, r.char_pos, r.char_out, r.field_overflow,
			r.fix_valid, r.sentence_done);
	endfunction

	// predict on every accepted byte, compare every accepted result
	always @(posedge clk) begin
		nsfe_pkg::out_item_t want;
		nsfe_pkg::out_item_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				aprs_on = cfg_ch.data[0];
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (expected_captures.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", show(got));
				end else begin
					want = expected_captures.pop_front();
					if (got.store_en !== want.store_en || got.field_id !== want.field_id ||
							got.char_pos !== want.char_pos || got.char_out !== want.char_out ||
							got.field_overflow !== want.field_overflow ||
							got.fix_valid !== want.fix_valid ||
							got.sentence_done !== want.sentence_done) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %s, got %s", show(want), show(got));
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready)
				expected_captures.push_back(parse_byte(rx_ch.data.byte_in));
		end
	end

	// receiver: random stall patterns, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen    <= hold_seq;
			hold_left    <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_span <= $urandom_range(20, 120);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 3) != 0);
				default: res_ch.ready <= (stall_span[2:0] != 3'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		rx_ch.valid        <= 1'b1;
		rx_ch.data.byte_in <= b;
		do @(posedge clk); while (!rx_ch.ready);
		burst_left--;
		bytes_sent++;
		if (burst_left == 0)
			rx_ch.valid <= 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// stop offering and hold until every outstanding result has drained
	task automatic wait_drained();
		if (burst_left != 0)
			rx_ch.valid <= 1'b0;
		burst_left = 0;
		// sample the queue away from the rising edge, after the checker has run
		do @(negedge clk); while (expected_captures.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_aprs_mode(input logic v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] content_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'h30 + 8'($urandom_range(0, 9));
		else if (r < 65)
			return 8'h2E;
		else if (r < 88)
			return 8'h41 + 8'($urandom_range(0, 25));
		else if (r < 93)
			return nsfe_pkg::CH_NEWLINE;
		else
			return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] fix_char();
		case ($urandom_range(0, 5))
			0: return nsfe_pkg::CH_A;
			1: return nsfe_pkg::CH_V;
			2: return nsfe_pkg::CH_ONE;
			3: return nsfe_pkg::CH_TWO;
			4: return 8'h30;
			default: return content_char();
		endcase
	endfunction

	task automatic send_sentence(input bit long_fields);
		string      tag;
		int         nf;
		int         flen;
		int         cut;
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: tag = "GPRMC";
			2, 3: tag = "GPGGA";
			4: tag = "GPGSA";
			5: tag = "GPVTG";
			6: tag = "GPGSV";
			7: tag = "GNRMC";
			8: tag = "GPZDA";
			default: tag = "GPGLL";
		endcase
		nf  = $urandom_range(7, 14);
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, nf) : 0;
		send_byte(nsfe_pkg::CH_DOLLAR);
		send_text(tag);
		for (int f = 1; f <= nf; f++) begin
			if (f == cut) begin
				// break off mid-sentence, sometimes with a NUL
				if ($urandom_range(0, 1) != 0)
					send_byte(nsfe_pkg::CH_NUL);
				return;
			end
			send_byte(nsfe_pkg::CH_COMMA);
			flen = (long_fields || $urandom_range(0, 15) == 0) ? $urandom_range(14, 22)
				: $urandom_range(0, 7);
			for (int k = 0; k < flen; k++) begin
				if (k == 0 && (f == 2 || f == 6))
					c = fix_char();
				else
					c = content_char();
				send_byte(c);
			end
		end
		send_text($sformatf("*%02X\r\n", $urandom_range(0, 255)));
	endtask

	task automatic test_special_bytes();
		send_byte(nsfe_pkg::CH_NUL);
		send_byte(8'hFF);
		send_text("$C,,A,\n");
		send_text("$SA,\n");
		send_text("$SV,x");
		send_text("$A,9\n");
		send_byte(nsfe_pkg::CH_NUL);
	endtask

	task automatic test_field_overflow();
		send_text("$GPGGA,123519.0012345678901,4807.038,N\n");
		send_sentence(1'b1);
		send_sentence(1'b1);
	endtask

	task automatic test_sentences(input int n);
		int stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at)
			send_sentence(1'b0);
	endtask

	// a wrapping comma count would land back on a captured field
	task automatic test_comma_saturation();
		send_text("$A");
		repeat (260) send_byte(nsfe_pkg::CH_COMMA);
		send_text("x,y\n");
	endtask

	task automatic test_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 9))
					0: b = nsfe_pkg::CH_NUL;
					1: b = nsfe_pkg::CH_DOLLAR;
					2: b = nsfe_pkg::CH_COMMA;
					3: b = nsfe_pkg::CH_NEWLINE;
					4: b = nsfe_pkg::CH_C;
					5: b = nsfe_pkg::CH_S;
					6: b = nsfe_pkg::CH_A;
					7: b = nsfe_pkg::CH_V;
					8: b = nsfe_pkg::CH_ONE;
					default: b = nsfe_pkg::CH_TWO;
				endcase
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_byte(b);
		end
	endtask

	// hold the result side off while bytes keep coming, then drain fully
	task automatic test_backpressure();
		hold_seq++;
		repeat (3) send_sentence(1'b0);
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		rx_ch.valid  = 1'b0;
		rx_ch.data   = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		res_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_bytes();
		test_field_overflow();
		test_sentences(200);
		wait_drained();
		write_aprs_mode(1'b1);
		test_sentences(200);
		test_comma_saturation();
		wait_drained();
		write_aprs_mode(1'b0);
		test_noise(200);
		test_backpressure();
		write_aprs_mode(1'b1);
		test_noise(100);
		test_sentences(150);
		wait_drained();
		write_aprs_mode(1'b0);
		test_sentences(80);
		wait_drained();
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
design/nsfe_pkg.sv
design/nsfe_chan_if.sv
design/nmea_sentence_field_extractor_unit.sv
dv/testbench.sv
